// ===== hw/rtl/sacep_pkg.sv =====
package sacep_pkg;

   localparam int VALUE_W = 32;
   localparam int CAP_W   = 16;

   localparam logic [CAP_W-1:0]   CAP_LIMIT = 16'd1000;
   localparam logic [VALUE_W-1:0] SIGN_FLIP = 32'h8000_0000;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DONE
   } state_type;

   // command broadcast along the cell row
   typedef struct packed {
      logic               insert;
      logic               shift;
      logic [VALUE_W-1:0] key;
   } cell_cmd_type;

   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctl_type;

endpackage

// ===== hw/rtl/sacep_cell.sv =====
module sacep_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  sacep_pkg::cell_cmd_type        cmd,
   input  logic [sacep_pkg::VALUE_W-1:0]  left_value,
   input  logic                           left_valid,
   input  logic                           left_gt,
   input  logic [sacep_pkg::VALUE_W-1:0]  right_value,
   input  logic                           right_valid,
   output logic [sacep_pkg::VALUE_W-1:0]  value,
   output logic                           valid,
   output logic                           gt
);
   import sacep_pkg::*;

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;
   logic               valid_ff;
   logic               valid_in;

   assign gt = valid_ff && (value_ff > cmd.key);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.shift) begin
         // drain toward the low end of the row
         value_in = right_value;
         valid_in = right_valid;
      end else if (cmd.insert) begin
         if (left_gt) begin
            value_in = left_value;
            valid_in = 1'b1;
         end else if (gt || (!valid_ff && left_valid)) begin
            value_in = cmd.key;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

// ===== hw/rtl/sacep_pair_scan.sv =====
module sacep_pair_scan #(
   parameter int PAIR_W = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sacep_pkg::scan_ctl_type       ctl,
   input  logic [sacep_pkg::VALUE_W-1:0] data,
   output logic [PAIR_W-1:0]             pairs
);
   import sacep_pkg::*;

   logic [VALUE_W-1:0] prev_ff;
   logic [VALUE_W-1:0] prev_in;
   logic               prev_valid_ff;
   logic               prev_valid_in;
   logic [PAIR_W-1:0]  pairs_ff;
   logic [PAIR_W-1:0]  pairs_in;

   always_comb begin
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      pairs_in      = pairs_ff;
      if (ctl.clear) begin
         prev_valid_in = 1'b0;
         pairs_in      = '0;
      end else if (ctl.step) begin
         if (prev_valid_ff && (prev_ff == data)) begin
            // matched pair: count it and skip both
            pairs_in      = pairs_ff + 1'b1;
            prev_valid_in = 1'b0;
         end else begin
            prev_in       = data;
            prev_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
         pairs_ff      <= '0;
      end else begin
         prev_valid_ff <= prev_valid_in;
         pairs_ff      <= pairs_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
   end

   assign pairs = pairs_ff;

endmodule

// ===== hw/rtl/sort_and_count_equal_pairs_unit.sv =====
// Sequence: with N values held (at most MAX_ITEMS), the request marked last starts a scan
// that drains the row through the pair scanner; ST_DONE then registers the response.
// Throughput: one request per cycle while loading; after the request marked last, req_tready
// stays low in ST_SCAN and ST_DONE; ST_DONE lasts while a response waits on rsp_tready.
// Reset: synchronous, clears all cell valid bits, the fill count, the cap and rsp_tvalid.
module sort_and_count_equal_pairs_unit #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,   // [31:0] value
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,   // [15:0] pair_count
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [15:0]                   csr_data
);
   import sacep_pkg::*;

   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int PAIR_W = $clog2(MAX_ITEMS / 2 + 1);
   localparam int CMP_W  = (PAIR_W > CAP_W) ? PAIR_W : CAP_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ITEMS);

   state_type          state_ff;
   state_type          state_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [CAP_W-1:0]   cap_ff;
   logic [CAP_W-1:0]   cap_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [CAP_W-1:0]   rsp_data_ff;
   logic [CAP_W-1:0]   rsp_data_in;

   logic               accept;
   logic               load_rsp;
   cell_cmd_type       cmd;
   scan_ctl_type       scan_ctl;
   logic [PAIR_W-1:0]  pairs;
   logic [CAP_W-1:0]   clamped;

   logic [VALUE_W-1:0] cell_value [MAX_ITEMS];
   logic               cell_valid [MAX_ITEMS];
   logic               cell_gt    [MAX_ITEMS];

   assign req_tready = (state_ff == ST_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_tlast) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // controls
   always_comb begin
      cmd.key        = req_tdata ^ SIGN_FLIP;
      cmd.insert     = accept && (count_ff != FULL_COUNT);
      cmd.shift      = (state_ff == ST_SCAN) && (count_ff != '0);
      scan_ctl.clear = accept && req_tlast;
      scan_ctl.step  = cmd.shift;
      load_rsp       = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.shift) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign cap_in = (csr_valid && csr_ready) ? csr_data : cap_ff;

   assign clamped = (CMP_W'(pairs) > CMP_W'(cap_ff)) ? cap_ff : CAP_W'(pairs);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         // drop the response when the cap is above the limit
         rsp_valid_in = (cap_ff <= CAP_LIMIT);
         rsp_data_in  = clamped;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic [VALUE_W-1:0] left_value;
      logic               left_valid;
      logic               left_gt;
      logic [VALUE_W-1:0] right_value;
      logic               right_valid;

      if (i == 0) begin : g_low
         assign left_value = '0;
         assign left_valid = 1'b1;
         assign left_gt    = 1'b0;
      end else begin : g_mid_low
         assign left_value = cell_value[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_high
         assign right_value = '0;
         assign right_valid = 1'b0;
      end else begin : g_mid_high
         assign right_value = cell_value[i+1];
         assign right_valid = cell_valid[i+1];
      end

      sacep_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_value  (left_value),
         .left_valid  (left_valid),
         .left_gt     (left_gt),
         .right_value (right_value),
         .right_valid (right_valid),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .gt          (cell_gt[i])
      );
   end

   sacep_pair_scan #(
      .PAIR_W (PAIR_W)
   ) u_pair_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .data  (cell_value[0]),
      .pairs (pairs)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count beyond row depth");

   a_scan_has_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && (count_ff != '0) |-> cell_valid[0])
      else $error("scan stepping over an empty cell");

   a_row_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> !cell_valid[0] && (count_ff == '0))
      else $error("row not drained at end of scan");

   a_empty_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) && !cell_valid[0] |-> (count_ff == '0))
      else $error("fill count disagrees with cell row");

endmodule

// ===== test/tb.sv =====
module tb;
   import sacep_pkg::*;

   localparam int STORE_DEPTH   = 1024;
   // worst-case scan of a full store plus margin, used before cap writes and at the end
   localparam int SETTLE_CYCLES = 2 * STORE_DEPTH + 32;
   localparam int STALL_LIMIT   = 20000;
   localparam int HOLD_CYCLES   = 400;

   localparam logic [VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] VAL_ZERO = 32'h0000_0000;
   localparam logic [VALUE_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

   // Tracks the set being loaded and the pair counts still owed by the block.
   class pair_scoreboard;
      logic signed [VALUE_W-1:0] set_vals[$];
      logic [CAP_W-1:0]          owed_counts[$];
      logic [CAP_W-1:0]          pair_cap;
      int                        fail_count;

      function new();
         pair_cap   = '0;
         fail_count = 0;
      endfunction

      function int pending();
         return owed_counts.size();
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         fail_count++;
      endtask

      function void note_request(logic [VALUE_W-1:0] value, logic last);
         logic signed [VALUE_W-1:0] key;
         logic [CAP_W-1:0]          clamped;
         int                        i;
         int                        j;
         int                        pairs;
         // drop values once the store is full
         if (set_vals.size() < STORE_DEPTH)
            set_vals.push_back(value);
         if (!last)
            return;
         for (i = 1; i < set_vals.size(); i++) begin
            key = set_vals[i];
            j   = i;
            while (j > 0 && set_vals[j-1] > key) begin
               set_vals[j] = set_vals[j-1];
               j--;
            end
            set_vals[j] = key;
         end
         pairs = 0;
         i     = 0;
         while (i + 1 < set_vals.size()) begin
            if (set_vals[i] == set_vals[i+1]) begin
               pairs++;
               i += 2;
            end else begin
               i++;
            end
         end
         if (pair_cap <= CAP_LIMIT) begin
            clamped = (pairs > int'(pair_cap)) ? pair_cap : CAP_W'(pairs);
            owed_counts.push_back(clamped);
         end
         set_vals.delete();
      endfunction

      task check_response(logic [CAP_W-1:0] got);
         logic [CAP_W-1:0] want;
         if (owed_counts.size() == 0) begin
            report_mismatch($sformatf("pair_count %0d with no set pending", got));
            return;
         end
         want = owed_counts.pop_front();
         if (got !== want)
            report_mismatch($sformatf("pair_count expected %0d got %0d", want, got));
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [31:0]        req_tdata;
   logic               req_tlast;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [15:0]        rsp_tdata;
   logic               csr_valid;
   logic               csr_ready;
   logic [15:0]        csr_data;

   pair_scoreboard     sb;
   logic [VALUE_W-1:0] set_buf[$];
   int                 send_idle_pct;
   int                 recv_stall_pct;
   logic               hold_go;
   int                 hold_left;
   int                 quiet_cycles;

   sort_and_count_equal_pairs_unit #(
      .MAX_ITEMS (STORE_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // response side: check, then pick ready for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata);
         if (hold_go) begin
            rsp_tready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
         end else if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left  <= hold_left - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake in %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [VALUE_W-1:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_request(value, last);
   endtask

   task automatic send_set();
      int i;
      for (i = 0; i < set_buf.size(); i++)
         send_request(set_buf[i], i == set_buf.size() - 1);
   endtask

   // lower valid, then hold until every owed count has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_cap(input logic [CAP_W-1:0] cap);
      wait_drained();
      // a suppressed result leaves the scan running with nothing owed
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid   <= 1'b0;
      sb.pair_cap = cap;
   endtask

   // mostly repeats from a small pool so equal pairs are common
   task automatic fill_random_set(input int n, input bit pool_only);
      logic [VALUE_W-1:0] pool[4];
      int                 style;
      int                 i;
      pool[0] = $urandom();
      pool[1] = $urandom();
      pool[2] = $urandom();
      pool[3] = pool[0] + 1;
      style   = pool_only ? 0 : $urandom_range(9);
      set_buf.delete();
      for (i = 0; i < n; i++) begin
         if (style < 6) begin
            set_buf.push_back(pool[$urandom_range(3)]);
         end else if (style < 8) begin
            set_buf.push_back($urandom());
         end else begin
            case ($urandom_range(4))
               0: set_buf.push_back(VAL_MIN);
               1: set_buf.push_back(VAL_MAX);
               2: set_buf.push_back(VAL_ZERO);
               3: set_buf.push_back(VAL_NEG1);
               default: set_buf.push_back(pool[0]);
            endcase
         end
      end
   endtask

   task automatic run_random_sets(input int n_items, input bit long_hold);
      int sent;
      int len;
      sent = 0;
      if (long_hold) begin
         hold_go <= 1'b1;
         @(posedge clock);
         hold_go <= 1'b0;
      end
      while (sent < n_items) begin
         len = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 64);
         fill_random_set(len, 1'b0);
         send_set();
         sent += len;
         if ($urandom_range(19) == 0)
            wait_drained();
      end
   endtask

   task automatic send_listed(input logic [VALUE_W-1:0] vals[$]);
      set_buf = vals;
      send_set();
   endtask

   initial begin
      sb             = new();
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      csr_valid      = 1'b0;
      csr_data       = '0;
      hold_go        = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed sets: extremes, single element, odd multiplicities, unsorted order
      write_cap(CAP_LIMIT);
      send_listed('{VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, VAL_ZERO, VAL_ZERO, VAL_ZERO});
      send_listed('{32'd5});
      send_listed('{VAL_NEG1, VAL_NEG1, VAL_NEG1, VAL_NEG1, 32'd1});
      send_listed('{32'd3, 32'd1, 32'd2, 32'd3, 32'd1, 32'd2, 32'd2});
      send_listed('{32'd10, -32'sd10, 32'd10, -32'sd10});

      // cap above the limit: nothing may come back
      write_cap(16'hFFFF);
      run_random_sets(30, 1'b0);

      write_cap(16'd0);
      send_idle_pct = 78;
      run_random_sets(80, 1'b0);

      write_cap(CAP_W'($urandom_range(1, 6)));
      send_idle_pct  = 0;
      recv_stall_pct = 78;
      run_random_sets(100, 1'b0);

      // long receiver hold while requests keep coming
      write_cap(CAP_W'($urandom_range(0, 1000)));
      send_idle_pct  = 11;
      recv_stall_pct = 11;
      run_random_sets(100, 1'b1);

      write_cap(CAP_LIMIT + 16'd1);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random_sets(30, 1'b0);

      write_cap(CAP_LIMIT);
      send_idle_pct  = 11;
      recv_stall_pct = 11;
      run_random_sets(60, 1'b0);

      write_cap(16'd2);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random_sets(100, 1'b1);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
